FILE: hw/rtl/line_clipper_outcode_macros.svh
// Assertion macros for the line clipper.
`ifndef LINE_CLIPPER_OUTCODE_MACROS_SVH
`define LINE_CLIPPER_OUTCODE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define LCO_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("line clipper check failed");
`define LCO_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("line clipper check failed");
`else
`define LCO_ASSERT(label, prop)
`define LCO_ASSERT_ALWAYS(label, prop)
`endif
`endif

FILE: hw/rtl/lco_pkg.sv
`timescale 1ns / 1ps
package lco_pkg;

  typedef logic [3:0] code_t;

  localparam code_t CODE_LEFT   = 4'd1;
  localparam code_t CODE_RIGHT  = 4'd2;
  localparam code_t CODE_BOTTOM = 4'd4;
  localparam code_t CODE_TOP    = 4'd8;

  localparam int MAX_CLIP_STEPS = 8;
  localparam int STEP_BITS      = $clog2(MAX_CLIP_STEPS + 1);

  localparam int CFG_INDEX_BITS = 4;
  typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;

  localparam cfg_index_t REG_X_MIN = 4'd0;
  localparam cfg_index_t REG_X_MAX = 4'd1;
  localparam cfg_index_t REG_Y_MIN = 4'd2;
  localparam cfg_index_t REG_Y_MAX = 4'd3;

  localparam int WIN_RESET_MIN = -100;
  localparam int WIN_RESET_MAX = 100;

  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    code_t start_code;
    code_t end_code;
  } code_pair_t;

  function automatic code_t make_code(input logic lt_x_min, input logic gt_x_max,
                                      input logic lt_y_min, input logic gt_y_max);
    code_t c;
    c = '0;
    if (lt_x_min) begin
      c = c | CODE_LEFT;
    end else if (gt_x_max) begin
      c = c | CODE_RIGHT;
    end
    if (lt_y_min) begin
      c = c | CODE_BOTTOM;
    end else if (gt_y_max) begin
      c = c | CODE_TOP;
    end
    return c;
  endfunction

endpackage

FILE: hw/rtl/lco_front.sv
`timescale 1ns / 1ps
module lco_front
  import lco_pkg::*;
#(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COORD_BITS-1:0] start_x,
  input  logic signed [COORD_BITS-1:0] start_y,
  input  logic signed [COORD_BITS-1:0] end_x,
  input  logic signed [COORD_BITS-1:0] end_y,
  input  logic signed [COORD_BITS-1:0] win_x_min,
  input  logic signed [COORD_BITS-1:0] win_x_max,
  input  logic signed [COORD_BITS-1:0] win_y_min,
  input  logic signed [COORD_BITS-1:0] win_y_max,
  output logic                         item_valid,
  input  logic                         item_ready,
  output logic signed [COORD_BITS-1:0] item_start_x,
  output logic signed [COORD_BITS-1:0] item_start_y,
  output logic signed [COORD_BITS-1:0] item_end_x,
  output logic signed [COORD_BITS-1:0] item_end_y,
  output code_pair_t                   item_codes
);

  assign in_ready = !item_valid || item_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  // classify both endpoints on the way in
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_start_x          <= start_x;
      item_start_y          <= start_y;
      item_end_x            <= end_x;
      item_end_y            <= end_y;
      item_codes.start_code <= make_code(start_x < win_x_min, start_x > win_x_max,
                                         start_y < win_y_min, start_y > win_y_max);
      item_codes.end_code   <= make_code(end_x < win_x_min, end_x > win_x_max,
                                         end_y < win_y_min, end_y > win_y_max);
    end
  end

endmodule

FILE: hw/rtl/lco_queue.sv
`timescale 1ns / 1ps
module lco_queue
  import lco_pkg::*;
#(
  parameter int DATA_BITS = 72
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push_valid,
  output logic                 push_ready,
  input  logic [DATA_BITS-1:0] push_data,
  output logic                 pop_valid,
  input  logic                 pop_ready,
  output logic [DATA_BITS-1:0] pop_data
);

  localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  logic [DATA_BITS-1:0] slots [QUEUE_DEPTH];
  logic [PTR_BITS-1:0]  wr_ptr;
  logic [PTR_BITS-1:0]  rd_ptr;
  logic [CNT_BITS-1:0]  count;
  logic                 push;
  logic                 pop;

  assign push_ready = count != CNT_BITS'(QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

FILE: hw/rtl/lco_div.sv
`timescale 1ns / 1ps
module lco_div #(
  parameter int COORD_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [2*COORD_BITS+1:0]   dividend,
  input  logic [COORD_BITS:0]       divisor,
  output logic                      done,
  output logic [COORD_BITS-1:0]     quotient
);

  localparam int DIVIDEND_BITS = 2 * COORD_BITS + 2;
  localparam int DIVISOR_BITS  = COORD_BITS + 1;
  localparam int CNT_BITS      = $clog2(DIVIDEND_BITS + 1);

  logic                     busy;
  logic [CNT_BITS-1:0]      count;
  logic [DIVIDEND_BITS-1:0] dvd;
  logic [DIVISOR_BITS-1:0]  dvs;
  logic [DIVISOR_BITS-1:0]  rem;
  logic [DIVISOR_BITS:0]    rem_shift;
  logic [DIVISOR_BITS:0]    rem_sub;
  logic                     fits;
  logic [DIVISOR_BITS-1:0]  rem_next;

  // one quotient bit per cycle, restoring
  always_comb begin
    rem_shift = {rem, dvd[DIVIDEND_BITS-1]};
    fits      = rem_shift >= {1'b0, dvs};
    rem_sub   = rem_shift - {1'b0, dvs};
    rem_next  = fits ? rem_sub[DIVISOR_BITS-1:0] : rem_shift[DIVISOR_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= CNT_BITS'(DIVIDEND_BITS);
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == CNT_BITS'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd      <= dividend;
      dvs      <= divisor;
      rem      <= '0;
      quotient <= '0;
    end else if (busy) begin
      dvd      <= {dvd[DIVIDEND_BITS-2:0], 1'b0};
      rem      <= rem_next;
      quotient <= {quotient[COORD_BITS-2:0], fits};
    end
  end

endmodule

FILE: hw/rtl/lco_clip.sv
`timescale 1ns / 1ps
module lco_clip
  import lco_pkg::*;
#(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic signed [COORD_BITS-1:0] win_x_min,
  input  logic signed [COORD_BITS-1:0] win_x_max,
  input  logic signed [COORD_BITS-1:0] win_y_min,
  input  logic signed [COORD_BITS-1:0] win_y_max,
  input  logic                         item_valid,
  output logic                         item_ready,
  input  logic signed [COORD_BITS-1:0] item_start_x,
  input  logic signed [COORD_BITS-1:0] item_start_y,
  input  logic signed [COORD_BITS-1:0] item_end_x,
  input  logic signed [COORD_BITS-1:0] item_end_y,
  input  code_pair_t                   item_codes,
  output logic                         div_start,
  output logic [2*COORD_BITS+1:0]      div_dividend,
  output logic [COORD_BITS:0]          div_divisor,
  input  logic                         div_done,
  input  logic [COORD_BITS-1:0]        div_quotient,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         accepted,
  output logic signed [COORD_BITS-1:0] clipped_start_x,
  output logic signed [COORD_BITS-1:0] clipped_start_y,
  output logic signed [COORD_BITS-1:0] clipped_end_x,
  output logic signed [COORD_BITS-1:0] clipped_end_y
);

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [COORD_BITS:0]   diff_t;
  typedef logic [COORD_BITS:0]          mag_t;
  typedef logic [2*COORD_BITS+1:0]      prod_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_MUL,
    S_START,
    S_DIV,
    S_CODE,
    S_DONE
  } state_t;

  function automatic diff_t sub(input coord_t a, input coord_t b);
    return diff_t'(a) - diff_t'(b);
  endfunction

  function automatic mag_t mag(input diff_t v);
    return v[COORD_BITS] ? mag_t'(-v) : mag_t'(v);
  endfunction

  state_t               state;
  coord_t               x0, y0, x1, y1;
  code_t                c0, c1;
  logic [STEP_BITS-1:0] steps;
  logic                 accept_flag;
  logic                 move_end;
  logic                 move_y;
  coord_t               base;
  coord_t               edge_val;
  diff_t                span;
  diff_t                num;
  diff_t                den;
  logic                 den_zero;
  logic                 neg;
  prod_t                prod;

  code_t  sel_code;
  diff_t  dx, dy;
  logic   pick_y;
  coord_t pick_base;
  coord_t pick_edge;
  diff_t  pick_span;
  diff_t  pick_num;
  diff_t  pick_den;
  coord_t q_mag;
  coord_t q_signed;
  coord_t new_coord;

  // pick the first violated edge: top, bottom, right, left
  always_comb begin
    sel_code = (c0 != '0) ? c0 : c1;
    dx       = sub(x1, x0);
    dy       = sub(y1, y0);
    if ((sel_code & CODE_TOP) != '0) begin
      pick_y    = 1'b0;
      pick_edge = win_y_max;
      pick_base = x0;
      pick_span = dx;
      pick_num  = sub(win_y_max, y0);
      pick_den  = dy;
    end else if ((sel_code & CODE_BOTTOM) != '0) begin
      pick_y    = 1'b0;
      pick_edge = win_y_min;
      pick_base = x0;
      pick_span = dx;
      pick_num  = sub(win_y_min, y0);
      pick_den  = dy;
    end else if ((sel_code & CODE_RIGHT) != '0) begin
      pick_y    = 1'b1;
      pick_edge = win_x_max;
      pick_base = y0;
      pick_span = dy;
      pick_num  = sub(win_x_max, x0);
      pick_den  = dx;
    end else begin
      pick_y    = 1'b1;
      pick_edge = win_x_min;
      pick_base = y0;
      pick_span = dy;
      pick_num  = sub(win_x_min, x0);
      pick_den  = dx;
    end
  end

  always_comb begin
    q_mag     = den_zero ? '0 : coord_t'(div_quotient);
    q_signed  = neg ? coord_t'(-q_mag) : q_mag;
    new_coord = coord_t'(base + q_signed);
  end

  assign item_ready   = state == S_IDLE;
  assign div_start    = state == S_START;
  assign div_dividend = prod;
  assign div_divisor  = mag(den);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      steps     <= '0;
    end else begin
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (item_valid) begin
            x0    <= item_start_x;
            y0    <= item_start_y;
            x1    <= item_end_x;
            y1    <= item_end_y;
            c0    <= item_codes.start_code;
            c1    <= item_codes.end_code;
            steps <= '0;
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if ((c0 | c1) == '0) begin
            accept_flag <= 1'b1;
            state       <= S_DONE;
          end else if ((c0 & c1) != '0 || steps == STEP_BITS'(MAX_CLIP_STEPS)) begin
            accept_flag <= 1'b0;
            state       <= S_DONE;
          end else begin
            steps    <= steps + 1'b1;
            move_end <= c0 == '0;
            move_y   <= pick_y;
            base     <= pick_base;
            edge_val <= pick_edge;
            span     <= pick_span;
            num      <= pick_num;
            den      <= pick_den;
            den_zero <= pick_den == '0;
            state    <= S_MUL;
          end
        end
        S_MUL: begin
          prod  <= prod_t'(mag(span)) * prod_t'(mag(num));
          neg   <= span[COORD_BITS] ^ num[COORD_BITS] ^ den[COORD_BITS];
          state <= S_START;
        end
        S_START: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            if (move_end) begin
              x1 <= move_y ? edge_val : new_coord;
              y1 <= move_y ? new_coord : edge_val;
            end else begin
              x0 <= move_y ? edge_val : new_coord;
              y0 <= move_y ? new_coord : edge_val;
            end
            state <= S_CODE;
          end
        end
        S_CODE: begin
          c0    <= make_code(x0 < win_x_min, x0 > win_x_max, y0 < win_y_min, y0 > win_y_max);
          c1    <= make_code(x1 < win_x_min, x1 > win_x_max, y1 < win_y_min, y1 > win_y_max);
          state <= S_DECIDE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid       <= 1'b1;
            accepted        <= accept_flag;
            clipped_start_x <= accept_flag ? x0 : '0;
            clipped_start_y <= accept_flag ? y0 : '0;
            clipped_end_x   <= accept_flag ? x1 : '0;
            clipped_end_y   <= accept_flag ? y1 : '0;
            state           <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: hw/rtl/line_clipper_outcode.sv
// A segment that needs no clipping passes the front end register and the queue, then the
// clip engine decides and registers its result; each clip step multiplies, runs the
// bit-serial divider and recodes both endpoints. A segment takes at most eight clip steps.
// The clip engine holds one segment at a time while the front end and a two-entry queue
// keep taking segments until the queue is full.
// Reset: window returns to -100..100 on both axes, queue and output are emptied.
`timescale 1ns / 1ps
`include "line_clipper_outcode_macros.svh"
module line_clipper_outcode
  import lco_pkg::*;
#(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  cfg_index_t                   cfg_index,
  input  logic [COORD_BITS-1:0]        cfg_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COORD_BITS-1:0] start_x,
  input  logic signed [COORD_BITS-1:0] start_y,
  input  logic signed [COORD_BITS-1:0] end_x,
  input  logic signed [COORD_BITS-1:0] end_y,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         accepted,
  output logic signed [COORD_BITS-1:0] clipped_start_x,
  output logic signed [COORD_BITS-1:0] clipped_start_y,
  output logic signed [COORD_BITS-1:0] clipped_end_x,
  output logic signed [COORD_BITS-1:0] clipped_end_y
);

  localparam int ITEM_BITS = 4 * COORD_BITS + $bits(code_pair_t);

  logic signed [COORD_BITS-1:0] win_x_min;
  logic signed [COORD_BITS-1:0] win_x_max;
  logic signed [COORD_BITS-1:0] win_y_min;
  logic signed [COORD_BITS-1:0] win_y_max;

  logic                         fr_valid;
  logic                         fr_ready;
  logic signed [COORD_BITS-1:0] fr_start_x, fr_start_y, fr_end_x, fr_end_y;
  code_pair_t                   fr_codes;

  logic                         qd_valid;
  logic                         qd_ready;
  logic [ITEM_BITS-1:0]         qd_data;
  logic signed [COORD_BITS-1:0] qd_start_x, qd_start_y, qd_end_x, qd_end_y;
  code_pair_t                   qd_codes;

  logic                         div_start;
  logic [2*COORD_BITS+1:0]      div_dividend;
  logic [COORD_BITS:0]          div_divisor;
  logic                         div_done;
  logic [COORD_BITS-1:0]        div_quotient;

  logic                         result_zero;
  logic                         start_in_win;
  logic                         end_in_win;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      win_x_min <= COORD_BITS'(WIN_RESET_MIN);
      win_x_max <= COORD_BITS'(WIN_RESET_MAX);
      win_y_min <= COORD_BITS'(WIN_RESET_MIN);
      win_y_max <= COORD_BITS'(WIN_RESET_MAX);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_X_MIN: win_x_min <= cfg_data;
        REG_X_MAX: win_x_max <= cfg_data;
        REG_Y_MIN: win_y_min <= cfg_data;
        REG_Y_MAX: win_y_max <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  lco_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .start_x      (start_x),
    .start_y      (start_y),
    .end_x        (end_x),
    .end_y        (end_y),
    .win_x_min    (win_x_min),
    .win_x_max    (win_x_max),
    .win_y_min    (win_y_min),
    .win_y_max    (win_y_max),
    .item_valid   (fr_valid),
    .item_ready   (fr_ready),
    .item_start_x (fr_start_x),
    .item_start_y (fr_start_y),
    .item_end_x   (fr_end_x),
    .item_end_y   (fr_end_y),
    .item_codes   (fr_codes)
  );

  lco_queue #(
    .DATA_BITS(ITEM_BITS)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (fr_valid),
    .push_ready (fr_ready),
    .push_data  ({fr_start_x, fr_start_y, fr_end_x, fr_end_y, fr_codes}),
    .pop_valid  (qd_valid),
    .pop_ready  (qd_ready),
    .pop_data   (qd_data)
  );

  assign {qd_start_x, qd_start_y, qd_end_x, qd_end_y, qd_codes} = qd_data;

  lco_div #(
    .COORD_BITS(COORD_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

  lco_clip #(
    .COORD_BITS(COORD_BITS)
  ) u_clip (
    .clk             (clk),
    .rst             (rst),
    .win_x_min       (win_x_min),
    .win_x_max       (win_x_max),
    .win_y_min       (win_y_min),
    .win_y_max       (win_y_max),
    .item_valid      (qd_valid),
    .item_ready      (qd_ready),
    .item_start_x    (qd_start_x),
    .item_start_y    (qd_start_y),
    .item_end_x      (qd_end_x),
    .item_end_y      (qd_end_y),
    .item_codes      (qd_codes),
    .div_start       (div_start),
    .div_dividend    (div_dividend),
    .div_divisor     (div_divisor),
    .div_done        (div_done),
    .div_quotient    (div_quotient),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .accepted        (accepted),
    .clipped_start_x (clipped_start_x),
    .clipped_start_y (clipped_start_y),
    .clipped_end_x   (clipped_end_x),
    .clipped_end_y   (clipped_end_y)
  );

  assign result_zero  = {clipped_start_x, clipped_start_y, clipped_end_x, clipped_end_y} == '0;
  assign start_in_win = clipped_start_x >= win_x_min && clipped_start_x <= win_x_max &&
                        clipped_start_y >= win_y_min && clipped_start_y <= win_y_max;
  assign end_in_win   = clipped_end_x >= win_x_min && clipped_end_x <= win_x_max &&
                        clipped_end_y >= win_y_min && clipped_end_y <= win_y_max;

  `LCO_ASSERT(a_reject_zero, out_valid && !accepted |-> result_zero)
  `LCO_ASSERT(a_accept_inside, out_valid && accepted |-> start_in_win && end_in_win)
  `LCO_ASSERT_ALWAYS(a_reset_empty, $past(rst) |-> !out_valid)

endmodule
